// ----- design/alr_pkg.sv -----
// shared constants for the antialiased line raster engine
`timescale 1ns / 1ps
package alr_pkg;
   localparam int COORD_FRAC_BITS_DEF = 6;
   localparam int SLOPE_FRAC_BITS_DEF = 16;
   localparam int COORD_BITS_DEF      = 13;
   localparam int BYTES_PER_PIXEL_DEF = 2;

   localparam int IN_W       = 18;
   localparam int ADDR_W     = 26;
   localparam int INTEN_W    = 8;
   localparam int COLOUR_W   = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 15;
   localparam int DIM_W      = 13;
   localparam int OFF_W      = 12;
   localparam int ROWB_W     = 15;

   localparam logic [CSR_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_X_OFFSET      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_Y_OFFSET      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ROW_BYTES     = 3'd4;

   localparam logic [DIM_W-1:0]  SCREEN_WIDTH_RST  = 13'd800;
   localparam logic [DIM_W-1:0]  SCREEN_HEIGHT_RST = 13'd480;
   localparam logic [ROWB_W-1:0] ROW_BYTES_RST     = 15'd1600;

   localparam logic FUNC_START   = 1'b0;
   localparam logic FUNC_ADVANCE = 1'b1;
endpackage

// ----- design/alr_div.sv -----
// bit-serial restoring divider for the line gradient
`timescale 1ns / 1ps
module alr_div #(
   parameter int NUM_W  = alr_pkg::IN_W + 1,
   parameter int Q_FRAC = alr_pkg::SLOPE_FRAC_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [NUM_W-1:0]  num,
   input  logic [NUM_W-1:0]  den,
   output logic              done,
   output logic [Q_FRAC:0]   quotient
);
   localparam int CNT_W = $clog2(Q_FRAC + 1);

   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [NUM_W-1:0]  rem_ff, rem_in;
   logic [Q_FRAC:0]   quo_ff, quo_in;
   logic [NUM_W:0]    rem2;
   logic              qbit;

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      rem2    = {rem_ff, 1'b0};
      qbit    = rem2 >= {1'b0, den};
      if (start) begin
         // numerator never exceeds the divisor, so the integer part is one bit
         run_in = 1'b1;
         cnt_in = CNT_W'(Q_FRAC);
         if (num >= den) begin
            rem_in = num - den;
            quo_in = (Q_FRAC+1)'(1);
         end else begin
            rem_in = num;
            quo_in = '0;
         end
      end else if (run_ff) begin
         rem_in = qbit ? NUM_W'(rem2 - {1'b0, den}) : NUM_W'(rem2);
         quo_in = {quo_ff[Q_FRAC-1:0], qbit};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

`ifndef NO_ASSERTIONS
   a_done_after_run: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(run_ff))
      else $error("divider done without a running division");
   a_no_run_on_done: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !run_ff)
      else $error("divider still running after done");
   a_start_runs: assert property (@(posedge clock) disable iff (reset)
      start |=> run_ff)
      else $error("divider did not start");
`endif
endmodule

// ----- design/antialiased_line_raster_top.sv -----
// antialiased (wu) line raster engine, top level
// a start beat holds the request side through swap, sort and the divider, then five shared
// multiplier steps per endpoint, each endpoint emitting its column as two result beats;
// an advance beat emits the next column as two result beats. result stalls hold the wait
// state and extend either beat. synchronous active-high reset clears the sequencer and line
// state and returns the screen registers to their defaults.
`timescale 1ns / 1ps
module antialiased_line_raster_top #(
   parameter int COORD_FRAC_BITS = alr_pkg::COORD_FRAC_BITS_DEF,
   parameter int SLOPE_FRAC_BITS = alr_pkg::SLOPE_FRAC_BITS_DEF,
   parameter int COORD_BITS      = alr_pkg::COORD_BITS_DEF,
   parameter int BYTES_PER_PIXEL = alr_pkg::BYTES_PER_PIXEL_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_func,
   input  logic signed [alr_pkg::IN_W-1:0]        req_start_x,
   input  logic signed [alr_pkg::IN_W-1:0]        req_start_y,
   input  logic signed [alr_pkg::IN_W-1:0]        req_end_x,
   input  logic signed [alr_pkg::IN_W-1:0]        req_end_y,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [COORD_BITS-1:0]           rsp_pixel_x,
   output logic signed [COORD_BITS-1:0]           rsp_pixel_y,
   output logic [alr_pkg::ADDR_W-1:0]             rsp_pixel_address,
   output logic [alr_pkg::INTEN_W-1:0]            rsp_intensity,
   output logic [alr_pkg::COLOUR_W-1:0]           rsp_pixel_colour,
   output logic                                   rsp_pixel_valid,
   output logic                                   rsp_line_done,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [alr_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [alr_pkg::CSR_DATA_W-1:0]         csr_data
);
   localparam int CF   = COORD_FRAC_BITS;
   localparam int SF   = SLOPE_FRAC_BITS;
   localparam int CB   = COORD_BITS;
   localparam int IW0  = alr_pkg::IN_W;
   localparam int DW   = IW0 + 1;
   localparam int SW   = SF + 2;
   localparam int MBW  = CF + 2;
   localparam int MW   = SW + MBW;
   localparam int CW   = 20 - CF;
   localparam int IW   = CW + SF;
   localparam int UP   = (SF >= CF) ? SF - CF : 0;
   localparam int DN   = (SF >= CF) ? 0 : CF - SF;
   localparam int VW   = (CB > alr_pkg::DIM_W) ? CB : alr_pkg::DIM_W;
   localparam int AW   = alr_pkg::ADDR_W;
   localparam int PW   = SF + CF + 1;

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_SWAP = 4'd1;
   localparam logic [3:0] ST_SORT = 4'd2;
   localparam logic [3:0] ST_DVS  = 4'd3;
   localparam logic [3:0] ST_DIV  = 4'd4;
   localparam logic [3:0] ST_EPA  = 4'd5;
   localparam logic [3:0] ST_EPB  = 4'd6;
   localparam logic [3:0] ST_EPC  = 4'd7;
   localparam logic [3:0] ST_EPD  = 4'd8;
   localparam logic [3:0] ST_EPE  = 4'd9;
   localparam logic [3:0] ST_ADV  = 4'd10;
   localparam logic [3:0] ST_LOAD = 4'd11;
   localparam logic [3:0] ST_WAIT = 4'd12;

   logic [3:0]                 state_ff, state_in;
   logic signed [IW0-1:0]      ax_ff, ax_in, ay_ff, ay_in, bx_ff, bx_in, by_ff, by_in;
   logic                       steep_ff, steep_in, active_ff, active_in;
   logic [DW-1:0]              dx_ff, dx_in, ady_ff, ady_in;
   logic                       dneg_ff, dneg_in;
   logic signed [SW-1:0]       slope_ff, slope_in;
   logic signed [MW-1:0]       mul_ff, mul_in;
   logic signed [IW-1:0]       yend_ff, yend_in, icpt_ff, icpt_in;
   logic signed [CW-1:0]       cur_ff, cur_in, fin_ff, fin_in;
   logic [7:0]                 i0_ff, i0_in, i1_ff, i1_in;
   logic [CB-1:0]              minor_ff, minor_in, major_ff, major_in;
   logic                       ep_ff, ep_in, mode_ff, mode_in, pix_ff, pix_in;
   logic                       last_ff, last_in;
   logic                       rv_ff, rv_in;
   logic [CB-1:0]              px_ff, px_in, py_ff, py_in;
   logic [AW-1:0]              addr_ff, addr_in;
   logic [7:0]                 inten_ff, inten_in;
   logic [alr_pkg::COLOUR_W-1:0] colour_ff, colour_in;
   logic                       pvalid_ff, pvalid_in, ldone_ff, ldone_in;
   logic [alr_pkg::DIM_W-1:0]  sw_ff, sh_ff;
   logic [alr_pkg::OFF_W-1:0]  xo_ff, yo_ff;
   logic [alr_pkg::ROWB_W-1:0] rb_ff;

   // working signals
   logic signed [DW-1:0]       sdx, sdy, e_dx, e_dy;
   logic [DW-1:0]              adx_r, ady_r;
   logic                       gt;
   logic                       div_start, div_done;
   logic [SF:0]                div_q;
   logic signed [IW0-1:0]      ex, ey;
   logic signed [IW0:0]        xh;
   logic signed [CW-1:0]       xe;
   logic [CF-1:0]              fp;
   logic signed [MBW-1:0]      gap, off;
   logic signed [SW-1:0]       mul_a;
   logic signed [MBW-1:0]      mul_b;
   logic signed [IW-1:0]       ys_ext, ys_fmt;
   logic [SF-1:0]              fy;
   logic [SF:0]                rf;
   logic [PW-1:0]              prod;
   logic [PW+8:0]              sprod;
   logic [SF+8:0]              s0;
   logic [SF+8:0]              s1;
   logic [CB-1:0]              mn, pxs, pys;
   logic                       on_screen;
   logic [VW:0]                xa, ya;
   logic [AW-1:0]              xprod;
   logic [VW+alr_pkg::ROWB_W:0] yprod;

   alr_div #(.NUM_W(DW), .Q_FRAC(SF)) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .num     (ady_ff),
      .den     (dx_ff),
      .done    (div_done),
      .quotient(div_q)
   );

   always_comb begin
      state_in = state_ff;
      ax_in = ax_ff; ay_in = ay_ff; bx_in = bx_ff; by_in = by_ff;
      steep_in = steep_ff; active_in = active_ff;
      dx_in = dx_ff; ady_in = ady_ff; dneg_in = dneg_ff;
      slope_in = slope_ff; yend_in = yend_ff; icpt_in = icpt_ff;
      cur_in = cur_ff; fin_in = fin_ff;
      i0_in = i0_ff; i1_in = i1_ff; minor_in = minor_ff; major_in = major_ff;
      ep_in = ep_ff; mode_in = mode_ff; pix_in = pix_ff; last_in = last_ff;
      rv_in = rv_ff; px_in = px_ff; py_in = py_ff; addr_in = addr_ff;
      inten_in = inten_ff; colour_in = colour_ff; pvalid_in = pvalid_ff; ldone_in = ldone_ff;
      div_start = 1'b0;

      // steepness from the raw endpoints
      sdx   = DW'(req_end_x) - DW'(req_start_x);
      sdy   = DW'(req_end_y) - DW'(req_start_y);
      adx_r = sdx[DW-1] ? DW'(-sdx) : DW'(sdx);
      ady_r = sdy[DW-1] ? DW'(-sdy) : DW'(sdy);

      // ordering on the swapped endpoints
      gt   = ax_ff > bx_ff;
      e_dx = DW'(bx_ff) - DW'(ax_ff);
      e_dy = DW'(by_ff) - DW'(ay_ff);

      // endpoint column geometry
      ex  = ep_ff ? bx_ff : ax_ff;
      ey  = ep_ff ? by_ff : ay_ff;
      xh  = (IW0+1)'(ex) + (IW0+1)'(signed'(1 << (CF - 1)));
      xe  = CW'(xh >>> CF);
      fp  = xh[CF-1:0];
      gap = ep_ff ? signed'(MBW'(fp)) : signed'(MBW'(1 << CF)) - signed'(MBW'(fp));
      off = signed'(MBW'(1 << (CF - 1))) - signed'(MBW'(fp));
      ys_ext = IW'(ey);
      ys_fmt = (SF >= CF) ? (ys_ext <<< UP) : (ys_ext >>> DN);

      fy    = (state_ff == ST_ADV) ? icpt_ff[SF-1:0] : yend_ff[SF-1:0];
      rf    = (SF+1)'(1 << SF) - (SF+1)'(fy);
      prod  = mul_ff[PW-1:0];
      sprod = {prod, 8'b0} - (PW+9)'(prod);
      s0    = {rf, 8'b0} - (SF+9)'(rf);
      s1    = (SF+9)'({fy, 8'b0}) - (SF+9)'(fy);

      mul_a = slope_ff;
      mul_b = off;
      unique case (state_ff)
         ST_EPC:  begin mul_a = signed'({1'b0, rf});   mul_b = gap; end
         ST_EPD:  begin mul_a = signed'({2'b0, fy});   mul_b = gap; end
         default: begin mul_a = slope_ff;              mul_b = off; end
      endcase
      mul_in = MW'(mul_a) * MW'(mul_b);

      // pixel formatting for the output register
      mn  = minor_ff + CB'(pix_ff);
      pxs = steep_ff ? mn : major_ff;
      pys = steep_ff ? major_ff : mn;
      on_screen = !pxs[CB-1] && !pys[CB-1] && (VW'(pxs) < VW'(sw_ff)) &&
                  (VW'(pys) < VW'(sh_ff));
      xa    = (VW+1)'(pxs) + (VW+1)'(xo_ff);
      ya    = (VW+1)'(pys) + (VW+1)'(yo_ff);
      xprod = AW'(xa) * AW'(BYTES_PER_PIXEL);
      yprod = (VW+alr_pkg::ROWB_W+1)'(ya) * (VW+alr_pkg::ROWB_W+1)'(rb_ff);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               mode_in = req_func;
               ep_in   = 1'b0;
               if (req_func == alr_pkg::FUNC_START) begin
                  ax_in = req_start_x; ay_in = req_start_y;
                  bx_in = req_end_x;   by_in = req_end_y;
                  steep_in = ady_r > adx_r;
                  state_in = ST_SWAP;
               end else if (active_ff) begin
                  state_in = ST_ADV;
               end
            end
         end
         ST_SWAP: begin
            if (steep_ff) begin
               ax_in = ay_ff; ay_in = ax_ff; bx_in = by_ff; by_in = bx_ff;
            end
            state_in = ST_SORT;
         end
         ST_SORT: begin
            if (gt) begin
               ax_in = bx_ff; ay_in = by_ff; bx_in = ax_ff; by_in = ay_ff;
            end
            dx_in   = e_dx[DW-1] ? DW'(-e_dx) : DW'(e_dx);
            ady_in  = e_dy[DW-1] ? DW'(-e_dy) : DW'(e_dy);
            dneg_in = gt ^ e_dy[DW-1];
            state_in = ST_DVS;
         end
         ST_DVS: begin
            div_start = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               if (dx_ff == '0) begin
                  slope_in = SW'(1 << SF);
               end else begin
                  slope_in = dneg_ff ? -signed'({1'b0, div_q}) : signed'({1'b0, div_q});
               end
               state_in = ST_EPA;
            end
         end
         ST_EPA: begin
            if (ep_ff) begin
               fin_in = xe - CW'(1);
            end else begin
               cur_in = xe + CW'(1);
            end
            state_in = ST_EPB;
         end
         ST_EPB: begin
            yend_in  = ys_fmt + IW'(mul_ff >>> CF);
            state_in = ST_EPC;
         end
         ST_EPC: begin
            state_in = ST_EPD;
         end
         ST_EPD: begin
            i0_in    = sprod[PW+6:PW-1];
            state_in = ST_EPE;
         end
         ST_EPE: begin
            i1_in    = sprod[PW+6:PW-1];
            minor_in = CB'(yend_ff >>> SF);
            major_in = CB'(IW'(xe));
            if (ep_ff) begin
               active_in = cur_ff <= fin_ff;
               last_in   = !(cur_ff <= fin_ff);
            end else begin
               icpt_in = yend_ff + IW'(slope_ff);
               last_in = 1'b0;
            end
            pix_in   = 1'b0;
            state_in = ST_LOAD;
         end
         ST_ADV: begin
            i0_in    = s0[SF+7:SF];
            i1_in    = s1[SF+7:SF];
            minor_in = CB'(icpt_ff >>> SF);
            major_in = CB'(IW'(cur_ff));
            last_in  = cur_ff >= fin_ff;
            active_in = !(cur_ff >= fin_ff);
            icpt_in  = icpt_ff + IW'(slope_ff);
            cur_in   = cur_ff + CW'(1);
            pix_in   = 1'b0;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            rv_in     = 1'b1;
            px_in     = pxs;
            py_in     = pys;
            inten_in  = pix_ff ? i1_ff : i0_ff;
            colour_in = pix_ff ? {i1_ff[7:3], i1_ff[7:2], i1_ff[7:3]}
                               : {i0_ff[7:3], i0_ff[7:2], i0_ff[7:3]};
            pvalid_in = on_screen;
            addr_in   = on_screen ? xprod + AW'(yprod) : '0;
            ldone_in  = pix_ff & last_ff;
            state_in  = ST_WAIT;
         end
         ST_WAIT: begin
            if (!rsp_stall) begin
               rv_in = 1'b0;
               if (!pix_ff) begin
                  pix_in   = 1'b1;
                  state_in = ST_LOAD;
               end else if (mode_ff == alr_pkg::FUNC_START && !ep_ff) begin
                  ep_in    = 1'b1;
                  state_in = ST_EPA;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         steep_ff  <= 1'b0;
         active_ff <= 1'b0;
         slope_ff  <= '0;
         icpt_ff   <= '0;
         cur_ff    <= '0;
         fin_ff    <= '0;
         rv_ff     <= 1'b0;
         sw_ff     <= alr_pkg::SCREEN_WIDTH_RST;
         sh_ff     <= alr_pkg::SCREEN_HEIGHT_RST;
         xo_ff     <= '0;
         yo_ff     <= '0;
         rb_ff     <= alr_pkg::ROW_BYTES_RST;
      end else begin
         state_ff  <= state_in;
         steep_ff  <= steep_in;
         active_ff <= active_in;
         slope_ff  <= slope_in;
         icpt_ff   <= icpt_in;
         cur_ff    <= cur_in;
         fin_ff    <= fin_in;
         rv_ff     <= rv_in;
         if (csr_valid) begin
            unique case (csr_index)
               alr_pkg::REG_SCREEN_WIDTH:  sw_ff <= alr_pkg::DIM_W'(csr_data);
               alr_pkg::REG_SCREEN_HEIGHT: sh_ff <= alr_pkg::DIM_W'(csr_data);
               alr_pkg::REG_X_OFFSET:      xo_ff <= alr_pkg::OFF_W'(csr_data);
               alr_pkg::REG_Y_OFFSET:      yo_ff <= alr_pkg::OFF_W'(csr_data);
               alr_pkg::REG_ROW_BYTES:     rb_ff <= alr_pkg::ROWB_W'(csr_data);
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      ax_ff <= ax_in; ay_ff <= ay_in; bx_ff <= bx_in; by_ff <= by_in;
      dx_ff <= dx_in; ady_ff <= ady_in; dneg_ff <= dneg_in;
      mul_ff <= mul_in; yend_ff <= yend_in;
      i0_ff <= i0_in; i1_ff <= i1_in; minor_ff <= minor_in; major_ff <= major_in;
      ep_ff <= ep_in; mode_ff <= mode_in; pix_ff <= pix_in; last_ff <= last_in;
      px_ff <= px_in; py_ff <= py_in; addr_ff <= addr_in;
      inten_ff <= inten_in; colour_ff <= colour_in;
      pvalid_ff <= pvalid_in; ldone_ff <= ldone_in;
   end

   assign req_stall         = state_ff != ST_IDLE;
   assign csr_ready         = 1'b1;
   assign rsp_valid         = rv_ff;
   assign rsp_pixel_x       = signed'(px_ff);
   assign rsp_pixel_y       = signed'(py_ff);
   assign rsp_pixel_address = addr_ff;
   assign rsp_intensity     = inten_ff;
   assign rsp_pixel_colour  = colour_ff;
   assign rsp_pixel_valid   = pvalid_ff;
   assign rsp_line_done     = ldone_ff;

`ifndef NO_ASSERTIONS
   a_valid_in_wait: assert property (@(posedge clock) disable iff (reset)
      rv_ff |-> state_ff == ST_WAIT)
      else $error("result beat shown outside the wait state");
   a_idle_no_result: assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> !rv_ff)
      else $error("request side open while a result beat is pending");
   a_done_on_second: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && ldone_ff) |-> pix_ff)
      else $error("line done flagged on the first pixel of a column");
   a_done_clears_active: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && ldone_ff) |-> !active_ff)
      else $error("line still active after its last beat");
`endif
endmodule

// ----- tb/sv/tb.sv -----
// self-checking testbench for the antialiased line raster engine
`timescale 1ns / 1ps
module tb;
   localparam int IN_W       = alr_pkg::IN_W;
   localparam int ADDR_W     = alr_pkg::ADDR_W;
   localparam int INTEN_W    = alr_pkg::INTEN_W;
   localparam int COLOUR_W   = alr_pkg::COLOUR_W;
   localparam int CSR_IDX_W  = alr_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W = alr_pkg::CSR_DATA_W;

   typedef struct packed {
      logic signed [12:0] x;
      logic signed [12:0] y;
      logic [ADDR_W-1:0]  addr;
      logic [7:0]         inten;
      logic [15:0]        colour;
      logic               pvalid;
      logic               done;
   } pixel_type;

   typedef struct {
      logic                   func;
      logic signed [IN_W-1:0] sx, sy, ex, ey;
      bit                     typed;
      pixel_type              first_pix;
   } stim_row_type;

   localparam longint ONE_C = 64;
   localparam longint ONE_F = 65536;
   localparam int     CYCLE_LIMIT = 400000;
   localparam int     HOLD_LEN = 300;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0, req_func = alr_pkg::FUNC_START;
   logic signed [IN_W-1:0] req_start_x = '0, req_start_y = '0, req_end_x = '0, req_end_y = '0;
   logic req_stall, rsp_valid, rsp_stall = 1'b0;
   logic signed [12:0] rsp_pixel_x, rsp_pixel_y;
   logic [ADDR_W-1:0] rsp_pixel_address;
   logic [INTEN_W-1:0] rsp_intensity;
   logic [COLOUR_W-1:0] rsp_pixel_colour;
   logic rsp_pixel_valid, rsp_line_done;
   logic csr_valid = 1'b0, csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = alr_pkg::REG_SCREEN_WIDTH;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // typed first-pixel expectation travels with the request beat
   logic      typed_on = 1'b0;
   pixel_type typed_pix = '0;

   antialiased_line_raster_top u_dut (.*);

   always #5 clock = ~clock;

   // predictor state
   longint scr_w = 800, scr_h = 480, off_x = 0, off_y = 0, row_b = 1600;
   bit     ln_active = 0, ln_steep = 0;
   longint col_cur = 0, col_last = 0, icept = 0, grad = 0;

   pixel_type pixel_q[$];
   int     errors = 0;
   int     sender_idle_pct = 0, rx_stall_pct = 0;
   int     hold_req = 0, hold_seen = 0, hold_cycles = 0;
   longint cycle_cnt = 0;

   function automatic pixel_type make_pixel(longint px, longint py, longint inten);
      pixel_type p;
      logic signed [12:0] xw, yw;
      longint xs, ys;
      logic [7:0] i;
      xw = px[12:0];
      yw = py[12:0];
      xs = xw;
      ys = yw;
      i = inten[7:0];
      p.x = xw;
      p.y = yw;
      p.pvalid = xs >= 0 && xs < scr_w && ys >= 0 && ys < scr_h;
      p.addr = p.pvalid ? ADDR_W'((xs + off_x) * 2 + (ys + off_y) * row_b) : '0;
      p.inten = i;
      p.colour = {i[7:3], i[7:2], i[7:3]};
      p.done = 1'b0;
      return p;
   endfunction

   task automatic push_column(longint col, longint row, longint i0, longint i1);
      if (ln_steep) begin
         pixel_q.push_back(make_pixel(row, col, i0));
         pixel_q.push_back(make_pixel(row + 1, col, i1));
      end else begin
         pixel_q.push_back(make_pixel(col, row, i0));
         pixel_q.push_back(make_pixel(col, row + 1, i1));
      end
   endtask

   task automatic end_column(longint x, longint y, bit first, output longint xe,
                             output longint yend);
      longint xh, fp, gap, yp, fy;
      xh = x + ONE_C / 2;
      xe = xh >>> 6;
      fp = xh - xe * ONE_C;
      gap = first ? ONE_C - fp : fp;
      yend = (y <<< 10) + ((grad * (xe * ONE_C - x)) >>> 6);
      yp = yend >>> 16;
      fy = yend - yp * ONE_F;
      push_column(xe, yp, (255 * (ONE_F - fy) * gap) >>> 22, (255 * fy * gap) >>> 22);
   endtask

   task automatic predict_beat(logic func, longint x0, longint y0, longint x1, longint y1);
      longint t, dx, dy, c1, c2, ye1, ye2, yp, fy;
      if (func == alr_pkg::FUNC_START) begin
         ln_steep = ((y1 > y0) ? y1 - y0 : y0 - y1) > ((x1 > x0) ? x1 - x0 : x0 - x1);
         if (ln_steep) begin
            t = x0; x0 = y0; y0 = t;
            t = x1; x1 = y1; y1 = t;
         end
         if (x0 > x1) begin
            t = x0; x0 = x1; x1 = t;
            t = y0; y0 = y1; y1 = t;
         end
         dx = x1 - x0;
         dy = y1 - y0;
         if (dx == 0) grad = ONE_F;
         else grad = (dy < 0) ? -(((-dy) <<< 16) / dx) : ((dy <<< 16) / dx);
         end_column(x0, y0, 1'b1, c1, ye1);
         end_column(x1, y1, 1'b0, c2, ye2);
         icept = ye1 + grad;
         col_cur = c1 + 1;
         col_last = c2 - 1;
         ln_active = col_cur <= col_last;
         pixel_q[$].done = !ln_active;
      end else if (ln_active) begin
         yp = icept >>> 16;
         fy = icept - yp * ONE_F;
         push_column(col_cur, yp, (255 * (ONE_F - fy)) >>> 16, (255 * fy) >>> 16);
         icept += grad;
         col_cur += 1;
         if (col_cur > col_last) begin
            ln_active = 0;
            pixel_q[$].done = 1'b1;
         end
      end
   endtask

   // acceptance on both channels, sampled at the edge
   always @(posedge clock) begin
      pixel_type e;
      int n;
      cycle_cnt <= cycle_cnt + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pixel_q.size() == 0) begin
            $display("%0t: expected no pixel, actual x=%0d y=%0d", $time, rsp_pixel_x,
                     rsp_pixel_y);
            errors++;
         end else begin
            e = pixel_q.pop_front();
            if (rsp_pixel_x !== e.x || rsp_pixel_y !== e.y || rsp_pixel_address !== e.addr ||
                rsp_intensity !== e.inten || rsp_pixel_colour !== e.colour ||
                rsp_pixel_valid !== e.pvalid || rsp_line_done !== e.done) begin
               $display("%0t: expected x=%0d y=%0d addr=%0h i=%0d c=%0h v=%0b d=%0b", $time,
                        e.x, e.y, e.addr, e.inten, e.colour, e.pvalid, e.done);
               $display("%0t: actual   x=%0d y=%0d addr=%0h i=%0d c=%0h v=%0b d=%0b", $time,
                        rsp_pixel_x, rsp_pixel_y, rsp_pixel_address, rsp_intensity,
                        rsp_pixel_colour, rsp_pixel_valid, rsp_line_done);
               errors++;
            end
         end
      end
      if (!reset && req_valid && !req_stall) begin
         n = pixel_q.size();
         predict_beat(req_func, req_start_x, req_start_y, req_end_x, req_end_y);
         if (typed_on && pixel_q.size() > n) pixel_q[n] = typed_pix;
      end
   end

   // receiver: random stalls plus an occasional long hold-off counted here
   always @(posedge clock) begin
      if (hold_req != hold_seen) begin
         hold_seen <= hold_req;
         hold_cycles <= HOLD_LEN;
         rsp_stall <= 1'b1;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rx_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (cycle_cnt >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic send_beat(logic func, longint sx, longint sy, longint ex, longint ey,
                            bit typed, pixel_type pix);
      int gap;
      gap = ($urandom_range(99) < sender_idle_pct) ? $urandom_range(12, 1) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= func;
      req_start_x <= IN_W'(sx);
      req_start_y <= IN_W'(sy);
      req_end_x <= IN_W'(ex);
      req_end_y <= IN_W'(ey);
      typed_on <= typed;
      typed_pix <= pix;
      do @(posedge clock); while (!(req_valid && !req_stall));
   endtask

   task automatic go_idle();
      req_valid <= 1'b0;
      typed_on <= 1'b0;
      @(posedge clock);
      while (pixel_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, longint val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= CSR_DATA_W'(val);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         alr_pkg::REG_SCREEN_WIDTH:  scr_w = val & 16'h1FFF;
         alr_pkg::REG_SCREEN_HEIGHT: scr_h = val & 16'h1FFF;
         alr_pkg::REG_X_OFFSET:      off_x = val & 16'hFFF;
         alr_pkg::REG_Y_OFFSET:      off_y = val & 16'hFFF;
         alr_pkg::REG_ROW_BYTES:     row_b = val & 16'h7FFF;
         default: ;
      endcase
   endtask

   task automatic set_screen(longint w, longint h, longint ox, longint oy, longint rb);
      write_reg(alr_pkg::REG_SCREEN_WIDTH, w);
      write_reg(alr_pkg::REG_SCREEN_HEIGHT, h);
      write_reg(alr_pkg::REG_X_OFFSET, ox);
      write_reg(alr_pkg::REG_Y_OFFSET, oy);
      write_reg(alr_pkg::REG_ROW_BYTES, rb);
   endtask

   function automatic stim_row_type row(logic f, longint sx, longint sy, longint ex,
                                        longint ey);
      stim_row_type r;
      r.func = f;
      r.sx = IN_W'(sx);
      r.sy = IN_W'(sy);
      r.ex = IN_W'(ex);
      r.ey = IN_W'(ey);
      r.typed = 0;
      r.first_pix = '0;
      return r;
   endfunction

   // random lines: mostly short well-formed lines followed by their advances
   task automatic random_lines(int n_items);
      int sent, adv;
      longint sx, sy, ex, ey;
      pixel_type none;
      none = '0;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(9) == 0) begin
            sx = $signed(IN_W'($urandom));
            sy = $signed(IN_W'($urandom));
            ex = $signed(IN_W'($urandom));
            ey = $signed(IN_W'($urandom));
         end else begin
            sx = longint'($urandom_range(60000)) - 2000;
            sy = longint'($urandom_range(40000)) - 2000;
            ex = sx + longint'($urandom_range(1600)) - 800;
            ey = sy + longint'($urandom_range(1600)) - 800;
         end
         if ($urandom_range(7) == 0) begin
            send_beat(alr_pkg::FUNC_ADVANCE, sx, ey, ex, sy, 0, none);
            sent++;
         end
         send_beat(alr_pkg::FUNC_START, sx, sy, ex, ey, 0, none);
         sent++;
         adv = $urandom_range(10);
         repeat (adv) begin
            send_beat(alr_pkg::FUNC_ADVANCE, $urandom, $urandom, $urandom, $urandom, 0, none);
            sent++;
         end
      end
   endtask

   initial begin
      stim_row_type dir_rows[$];
      stim_row_type r;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      dir_rows.push_back(row(alr_pkg::FUNC_ADVANCE, 0, 0, 0, 0));   // no active line, ignored
      // degenerate line at the origin: half coverage on the endpoint pixel
      r = row(alr_pkg::FUNC_START, 0, 0, 0, 0);
      r.typed = 1;
      r.first_pix = '{x: 0, y: 0, addr: 0, inten: 127, colour: 16'h7BEF, pvalid: 1, done: 0};
      dir_rows.push_back(r);
      // endpoint left of the screen: not written, address zero
      r = row(alr_pkg::FUNC_START, -640, 0, -640, 0);
      r.typed = 1;
      r.first_pix = '{x: -10, y: 0, addr: 0, inten: 127, colour: 16'h7BEF, pvalid: 0, done: 0};
      dir_rows.push_back(r);
      dir_rows.push_back(row(alr_pkg::FUNC_START, 64, 64, 640, 192));
      repeat (3) dir_rows.push_back(row(alr_pkg::FUNC_ADVANCE, 0, 0, 0, 0));
      dir_rows.push_back(row(alr_pkg::FUNC_START, 100, 10, 130, 900));
      repeat (2) dir_rows.push_back(row(alr_pkg::FUNC_ADVANCE, 0, 0, 0, 0));
      // restart mid-line, endpoints reversed
      dir_rows.push_back(row(alr_pkg::FUNC_START, 640, 320, 64, 64));
      dir_rows.push_back(row(alr_pkg::FUNC_ADVANCE, 0, 0, 0, 0));
      dir_rows.push_back(row(alr_pkg::FUNC_START, 131071, 131071, -131072, -131072));
      dir_rows.push_back(row(alr_pkg::FUNC_ADVANCE, 0, 0, 0, 0));
      dir_rows.push_back(row(alr_pkg::FUNC_START, -131072, 131071, 131071, -131072));
      dir_rows.push_back(row(alr_pkg::FUNC_START, 95, 33, 417, 290));
      dir_rows.push_back(row(alr_pkg::FUNC_ADVANCE, -1, -1, -1, -1));
      dir_rows.push_back(row(alr_pkg::FUNC_START, 0, 0, 200, 0));
      repeat (3) dir_rows.push_back(row(alr_pkg::FUNC_ADVANCE, 0, 0, 0, 0));
      foreach (dir_rows[i])
         send_beat(dir_rows[i].func, dir_rows[i].sx, dir_rows[i].sy, dir_rows[i].ex,
                   dir_rows[i].ey, dir_rows[i].typed, dir_rows[i].first_pix);
      go_idle();

      // large screen and largest offsets, no idling
      set_screen(4096, 4096, 4095, 4095, 16384);
      random_lines(25);
      // long receiver hold-off while the sender keeps offering
      hold_req <= hold_req + 1;
      random_lines(10);
      go_idle();

      // smallest screen, sender mostly idle
      set_screen(1, 1, 0, 0, 2);
      sender_idle_pct = 88;
      random_lines(20);
      go_idle();

      // mid-range screen, receiver mostly stalling, sender pause until drained
      set_screen(640, 400, 17, 9, 1282);
      sender_idle_pct = 0;
      rx_stall_pct = 88;
      random_lines(15);
      go_idle();
      sender_idle_pct = 16;
      rx_stall_pct = 16;
      random_lines(20);
      go_idle();

      if (errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
